/* rtl/ptdf_pkg.sv */
// ----------------------------------------------------------------------------
// Per-type timestamp duplicate filter package
// Shared opcodes, verdict codes and the command and status types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptdf_pkg;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] VERDICT_NEW  = 2'd0;
    localparam logic [1:0] VERDICT_DUP  = 2'd1;
    localparam logic [1:0] VERDICT_DROP = 2'd2;
    localparam logic [1:0] VERDICT_NONE = 2'd3;

    typedef struct packed {
        logic load;
        logic read;
        logic commit;
    } ptdf_cmd_t;

    typedef struct packed {
        logic out_hold;
    } ptdf_stat_t;

endpackage

/* rtl/ptdf_ctrl.sv */
// ----------------------------------------------------------------------------
// Per-type timestamp duplicate filter controller
// Steps each accepted item through table read and commit, and holds the
// commit while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module ptdf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ptdf_pkg::ptdf_stat_t  stat,
    output ptdf_pkg::ptdf_cmd_t   cmd
);
    import ptdf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.read   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!stat.out_hold)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ptdf_datapath.sv */
// ----------------------------------------------------------------------------
// Per-type timestamp duplicate filter datapath
// Holds the item, the per-type stamp memories with their valid and seen flags,
// the classification compare and the output register.
// ----------------------------------------------------------------------------
module ptdf_datapath
#(
    parameter int NUM_TYPES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptdf_pkg::ptdf_cmd_t   cmd,
    output ptdf_pkg::ptdf_stat_t  stat,
    input  logic [1:0]            opcode,
    input  logic [7:0]            packet_type,
    input  logic [63:0]           stamp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            verdict,
    output logic                  bad_type
);
    import ptdf_pkg::*;

    localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [8:0] TYPE_LIMIT = 9'(NUM_TYPES);

    logic [1:0]           op_reg;
    logic [AW-1:0]        idx_reg;
    logic [63:0]          stamp_reg;
    logic                 in_range_reg;

    logic [63:0]          rx_mem_reg  [NUM_TYPES];
    logic [63:0]          ack_mem_reg [NUM_TYPES];
    logic [63:0]          rx_rd_reg;
    logic [63:0]          ack_rd_reg;

    logic [NUM_TYPES-1:0] rx_valid_reg;
    logic [NUM_TYPES-1:0] rx_valid_next;
    logic [NUM_TYPES-1:0] ack_valid_reg;
    logic [NUM_TYPES-1:0] ack_valid_next;
    logic [NUM_TYPES-1:0] rx_seen_reg;
    logic [NUM_TYPES-1:0] rx_seen_next;
    logic [NUM_TYPES-1:0] ack_seen_reg;
    logic [NUM_TYPES-1:0] ack_seen_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           verdict_reg;
    logic [1:0]           verdict_next;
    logic                 bad_type_reg;
    logic                 bad_type_next;

    logic [63:0]          rx_cur;
    logic [63:0]          ack_cur;
    logic                 rx_we;
    logic                 ack_we;
    logic [63:0]          rx_wdata;
    logic [63:0]          ack_wdata;

    assign stat.out_hold = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign bad_type      = bad_type_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode;
            idx_reg      <= AW'(packet_type);
            stamp_reg    <= stamp;
            in_range_reg <= ({1'b0, packet_type} < TYPE_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rx_rd_reg  <= rx_mem_reg[idx_reg];
            ack_rd_reg <= ack_mem_reg[idx_reg];
        end
        if (rx_we)
        begin
            rx_mem_reg[idx_reg] <= rx_wdata;
        end
        if (ack_we)
        begin
            ack_mem_reg[idx_reg] <= ack_wdata;
        end
    end

    assign rx_cur  = rx_valid_reg[idx_reg]  ? rx_rd_reg  : 64'd0;
    assign ack_cur = ack_valid_reg[idx_reg] ? ack_rd_reg : 64'd0;

    always_comb
    begin
        rx_we          = 1'b0;
        ack_we         = 1'b0;
        rx_wdata       = stamp_reg;
        ack_wdata      = stamp_reg;
        rx_valid_next  = rx_valid_reg;
        ack_valid_next = ack_valid_reg;
        rx_seen_next   = rx_seen_reg;
        ack_seen_next  = ack_seen_reg;
        verdict_next   = verdict_reg;
        bad_type_next  = bad_type_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            verdict_next   = VERDICT_NONE;
            bad_type_next  = 1'b0;
            if (op_reg != OP_UNUSED && !in_range_reg)
            begin
                bad_type_next = 1'b1;
                if (op_reg == OP_PACKET)
                begin
                    verdict_next = VERDICT_DROP;
                end
            end
            else
            begin
                case (op_reg)
                    OP_PACKET:
                    begin
                        if (stamp_reg < rx_cur)
                        begin
                            verdict_next = VERDICT_DROP;
                        end
                        else if (stamp_reg > rx_cur || !rx_seen_reg[idx_reg])
                        begin
                            verdict_next           = VERDICT_NEW;
                            rx_we                  = 1'b1;
                            rx_valid_next[idx_reg] = 1'b1;
                            rx_seen_next[idx_reg]  = 1'b1;
                        end
                        else if (stamp_reg == ack_cur && ack_seen_reg[idx_reg])
                        begin
                            verdict_next = VERDICT_DUP;
                        end
                        else
                        begin
                            verdict_next = VERDICT_DROP;
                        end
                    end
                    OP_ACK:
                    begin
                        if (stamp_reg > ack_cur || !ack_seen_reg[idx_reg])
                        begin
                            ack_we                  = 1'b1;
                            ack_valid_next[idx_reg] = 1'b1;
                            ack_seen_next[idx_reg]  = 1'b1;
                        end
                    end
                    OP_FORGET:
                    begin
                        rx_we                   = 1'b1;
                        ack_we                  = 1'b1;
                        rx_wdata                = 64'd0;
                        ack_wdata               = 64'd0;
                        rx_valid_next[idx_reg]  = 1'b1;
                        ack_valid_next[idx_reg] = 1'b1;
                    end
                    default:
                    begin
                        verdict_next = VERDICT_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= '0;
            ack_valid_reg <= '0;
            rx_seen_reg   <= '0;
            ack_seen_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_valid_reg  <= rx_valid_next;
            ack_valid_reg <= ack_valid_next;
            rx_seen_reg   <= rx_seen_next;
            ack_seen_reg  <= ack_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        bad_type_reg <= bad_type_next;
    end

endmodule

/* rtl/per_type_timestamp_dup_filter.sv */
// ----------------------------------------------------------------------------
// Per-type timestamp duplicate filter
// Classifies control packets against the newest received and acknowledged
// timestamps kept for each packet type, and records acks and forget requests.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   opcode, packet_type, stamp
//   out      out_valid / out_stall verdict, bad_type
//
// Each item steps through capture, stamp memory read, then commit. The read
// step comes from the registered output of the per-type stamp memories.
// Reset clears the valid and seen flags at once, so the block is ready in
// the first cycle after reset. A stalled result holds the commit of the
// next item; the input is stalled until that commit.
// ----------------------------------------------------------------------------
module per_type_timestamp_dup_filter
#(
    parameter int NUM_TYPES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  packet_type,
    input  logic [63:0] stamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic        bad_type
);
    import ptdf_pkg::*;

    ptdf_cmd_t  cmd;
    ptdf_stat_t stat;

    ptdf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptdf_datapath
    #(
        .NUM_TYPES (NUM_TYPES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .packet_type (packet_type),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .bad_type    (bad_type)
    );

endmodule
